// ===== rtl/zbfs_pkg.sv =====
package zbfs_pkg;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int CFG_W   = 9;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PUT   = 2'd1,
		OP_GET   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_BOUNDS   = 2'd1,
		STS_HIDDEN   = 2'd2,
		STS_NEGATIVE = 2'd3
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic signed [15:0] red_in;
		logic signed [15:0] green_in;
		logic signed [15:0] blue_in;
		logic signed [15:0] alpha_in;
		logic signed [31:0] depth_in;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [11:0]        red_out;
		logic [11:0]        green_out;
		logic [11:0]        blue_out;
		logic signed [15:0] alpha_out;
		logic [30:0]        depth_out;
	} result_t;

	// one stored pixel: colour, alpha and depth in a single memory word
	typedef struct packed {
		logic [11:0] red;
		logic [11:0] green;
		logic [11:0] blue;
		logic [15:0] alpha;
		logic [30:0] depth;
	} pixel_t;

	localparam pixel_t BG_PIXEL = '{
		red:   12'(127 << 4),
		green: 12'(111 << 4),
		blue:  12'(95 << 4),
		alpha: 16'd1,
		depth: 31'h7FFF_FFFF
	};

	localparam logic [11:0] COLOUR_MAX = 12'd4095;

	// clear sweep control from the sequencer to the pixel pipeline
	typedef struct packed {
		logic busy;
		logic done;
	} clr_ctl_t;

endpackage

// ===== rtl/zbfs_cfg.sv =====
module zbfs_cfg #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [zbfs_pkg::PADDR_W-1:0]  paddr,
	input  logic [zbfs_pkg::PDATA_W-1:0]  pwdata,
	output logic [zbfs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [WW-1:0]                 active_width,
	output logic [HW-1:0]                 active_height
);

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	logic [zbfs_pkg::CFG_W-1:0] width_q;
	logic [zbfs_pkg::CFG_W-1:0] height_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= zbfs_pkg::CFG_W'(256);
			height_q <= zbfs_pkg::CFG_W'(256);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[zbfs_pkg::CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[zbfs_pkg::CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = zbfs_pkg::PDATA_W'(width_q);
			REG_HEIGHT: prdata = zbfs_pkg::PDATA_W'(height_q);
		endcase
	end

	// zero acts as one, anything beyond the store acts as its maximum
	always_comb begin
		if (width_q == '0)
			active_width = WW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			active_width = WW'(MAX_WIDTH);
		else
			active_width = WW'(width_q);

		if (height_q == '0)
			active_height = HW'(1);
		else if (32'(height_q) > 32'(MAX_HEIGHT))
			active_height = HW'(MAX_HEIGHT);
		else
			active_height = HW'(height_q);
	end

endmodule

// ===== rtl/zbfs_pipe.sv =====
module zbfs_pipe #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	localparam int WW   = $clog2(MAX_WIDTH + 1),
	localparam int HW   = $clog2(MAX_HEIGHT + 1),
	localparam int SIZE = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW   = (SIZE > 1) ? $clog2(SIZE) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  zbfs_pkg::item_t      item,
	input  logic                 item_valid,
	output logic                 item_ready,
	output zbfs_pkg::result_t    result,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  logic [WW-1:0]        active_width,
	input  logic [HW-1:0]        active_height,
	input  zbfs_pkg::clr_ctl_t   ctl,
	input  logic [AW-1:0]        sweep_addr,
	output logic                 clear_request
);

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW = YW + WW;

	function automatic logic [11:0] clamp(input logic signed [15:0] c);
		if (c[15])
			return 12'd0;
		else if (c[14:12] != 3'd0)
			return zbfs_pkg::COLOUR_MAX;
		else
			return c[11:0];
	endfunction

	zbfs_pkg::pixel_t mem [SIZE];

	// entry stage
	logic          accept;
	logic          x_ok;
	logic          y_ok;
	logic [PW-1:0] prod;
	logic [AW-1:0] rd_addr;

	// test stage
	logic               valid_s1;
	logic               swept_s1;
	zbfs_pkg::op_t      op_s1;
	logic               ok_s1;
	logic [AW-1:0]      addr_s1;
	logic [11:0]        red_s1;
	logic [11:0]        green_s1;
	logic [11:0]        blue_s1;
	logic [15:0]        alpha_s1;
	logic [31:0]        depth_s1;
	zbfs_pkg::pixel_t   rd_data_s1;
	zbfs_pkg::pixel_t   fwd_data_s1;
	logic               fwd_hit_s1;
	zbfs_pkg::pixel_t   cur;
	zbfs_pkg::pixel_t   new_pix;
	zbfs_pkg::result_t  res;
	logic               put_ok;
	logic               advance;
	logic               pipe_we;

	// memory write port
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	zbfs_pkg::pixel_t   mem_wd;

	zbfs_pkg::result_t  result_q;
	logic               result_valid_q;

	assign x_ok = !item.pixel_x[15] && (16'(item.pixel_x) < 16'(active_width));
	assign y_ok = !item.pixel_y[15] && (16'(item.pixel_y) < 16'(active_height));
	assign prod = PW'(item.pixel_y[YW-1:0]) * PW'(active_width);
	assign rd_addr = AW'(prod + PW'(item.pixel_x[XW-1:0]));

	assign advance = valid_s1 && (!result_valid_q || result_ready)
	                 && (op_s1 != zbfs_pkg::OP_CLEAR || swept_s1);
	assign item_ready = !ctl.busy && (!valid_s1 || advance);
	assign accept = item_valid && item_ready;
	assign clear_request = valid_s1 && op_s1 == zbfs_pkg::OP_CLEAR && !swept_s1;

	// a write in the cycle of the read is not seen by the memory read
	assign cur = fwd_hit_s1 ? fwd_data_s1 : rd_data_s1;
	assign new_pix = '{red: red_s1, green: green_s1, blue: blue_s1,
	                   alpha: alpha_s1, depth: depth_s1[30:0]};

	always_comb begin
		res = '0;
		put_ok = 1'b0;
		unique case (op_s1)
			zbfs_pkg::OP_PUT: begin
				if (!ok_s1)
					res.status = zbfs_pkg::STS_BOUNDS;
				else if (depth_s1[31])
					res.status = zbfs_pkg::STS_NEGATIVE;
				else if (depth_s1[30:0] > cur.depth)
					res.status = zbfs_pkg::STS_HIDDEN;
				else
					put_ok = 1'b1;
			end
			zbfs_pkg::OP_GET: begin
				if (!ok_s1) begin
					res.status = zbfs_pkg::STS_BOUNDS;
				end else begin
					res.red_out   = cur.red;
					res.green_out = cur.green;
					res.blue_out  = cur.blue;
					res.alpha_out = cur.alpha;
					res.depth_out = cur.depth;
				end
			end
			zbfs_pkg::OP_CLEAR, zbfs_pkg::OP_NONE: ;
		endcase
	end

	assign pipe_we = advance && put_ok;
	assign mem_we  = ctl.busy || pipe_we;
	assign mem_wa  = ctl.busy ? sweep_addr : addr_s1;
	assign mem_wd  = ctl.busy ? zbfs_pkg::BG_PIXEL : new_pix;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (accept)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= item.operation;
			ok_s1       <= x_ok && y_ok;
			addr_s1     <= rd_addr;
			red_s1      <= clamp(item.red_in);
			green_s1    <= clamp(item.green_in);
			blue_s1     <= clamp(item.blue_in);
			alpha_s1    <= item.alpha_in;
			depth_s1    <= item.depth_in;
			fwd_hit_s1  <= pipe_we && addr_s1 == rd_addr;
			fwd_data_s1 <= new_pix;
		end
		if (advance)
			result_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			swept_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (accept)
				swept_s1 <= 1'b0;
			else if (ctl.done)
				swept_s1 <= 1'b1;

			if (advance)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ===== rtl/zbuffer_frame_store_unit.sv =====
// Depth-buffered pixel store with a row-major pixel memory of MAX_WIDTH*MAX_HEIGHT words.
// Items enter on item/item_valid/item_ready: clear, put with depth test, get, or none.
// Every item returns one result on result/result_valid/result_ready with a status;
// a get also returns the stored colour, alpha and depth.
// The active resolution is set through the APB port: frame_width at 0x0, frame_height
// at 0x4. Write them only while the block is idle; the block itself does not enforce this.
// Put and get: one item per cycle while results are taken; the item is registered in the
// test stage, then its result in the result register. The memory read-modify-write loop
// sets that rate; a put to the entry the next item reads is forwarded from a register.
// Clear: the sequencer sweeps all MAX_WIDTH*MAX_HEIGHT entries one entry per cycle
// (65536 at the defaults), with item_ready low; its result follows the sweep.
// After reset the same sweep runs first, with item_ready low until it ends;
// configuration writes are taken throughout.
// A stalled receiver holds the result register; one further item is still taken
// into the test stage, after which item_ready drops until the result is taken.
module zbuffer_frame_store_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  zbfs_pkg::item_t               item,
	input  logic                          item_valid,
	output logic                          item_ready,
	output zbfs_pkg::result_t             result,
	output logic                          result_valid,
	input  logic                          result_ready,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [zbfs_pkg::PADDR_W-1:0]  paddr,
	input  logic [zbfs_pkg::PDATA_W-1:0]  pwdata,
	output logic [zbfs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW   = (SIZE > 1) ? $clog2(SIZE) : 1;
	localparam logic [AW-1:0] LAST = AW'(SIZE - 1);

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_CLEAR = 2'b10
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clear_index_q;
	zbfs_pkg::clr_ctl_t ctl;
	logic               clear_request;
	logic [WW-1:0]      active_width;
	logic [HW-1:0]      active_height;

	assign ctl.busy = state_q == ST_CLEAR;
	assign ctl.done = ctl.busy && clear_index_q == LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clear_index_q <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (clear_request)
						state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (ctl.done) begin
						state_q       <= ST_RUN;
						clear_index_q <= '0;
					end else begin
						clear_index_q <= clear_index_q + AW'(1);
					end
				end
				default: begin
					state_q       <= ST_CLEAR;
					clear_index_q <= '0;
				end
			endcase
		end
	end

	zbfs_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.active_width  (active_width),
		.active_height (active_height)
	);

	zbfs_pipe #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.result        (result),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.active_width  (active_width),
		.active_height (active_height),
		.ctl           (ctl),
		.sweep_addr    (clear_index_q),
		.clear_request (clear_request)
	);

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	localparam int FRAME_MAX = 256;
	localparam int STORE_DEPTH = FRAME_MAX * FRAME_MAX;
	localparam int PHASE_COUNT = 10;
	localparam int PHASE_ITEMS = 193;
	localparam longint CYCLE_LIMIT = 2_000_000;
	localparam logic [zbfs_pkg::PADDR_W-1:0] REG_WIDTH = 3'h0;
	localparam logic [zbfs_pkg::PADDR_W-1:0] REG_HEIGHT = 3'h4;

	localparam zbfs_pkg::pixel_t BACKGROUND = '{
		red: 12'd2032, green: 12'd1776, blue: 12'd1520, alpha: 16'd1, depth: 31'h7FFF_FFFF
	};

	typedef struct {
		zbfs_pkg::item_t   it;
		bit                typed;
		zbfs_pkg::result_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	zbfs_pkg::item_t item;
	logic item_valid;
	logic item_ready;
	zbfs_pkg::result_t result;
	logic result_valid;
	logic result_ready = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [zbfs_pkg::PADDR_W-1:0] paddr;
	logic [zbfs_pkg::PDATA_W-1:0] pwdata;
	logic [zbfs_pkg::PDATA_W-1:0] prdata;
	logic pready;

	// model of the frame store and its active resolution
	zbfs_pkg::pixel_t px_mem [STORE_DEPTH];
	logic [8:0] cfg_width;
	logic [8:0] cfg_height;

	zbfs_pkg::result_t expected_px[$];
	zbfs_pkg::result_t want_px;
	int fail_count;
	longint cycle_count;
	int unsigned stall_mode;
	int unsigned stall_span;
	int unsigned rx_tick;

	zbuffer_frame_store_unit #(
		.MAX_WIDTH(FRAME_MAX),
		.MAX_HEIGHT(FRAME_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.result(result),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void wipe_frame_model();
		int i;
		for (i = 0; i < STORE_DEPTH; i++)
			px_mem[i] = BACKGROUND;
	endfunction

	function automatic int eff_dim(logic [8:0] r);
		if (r == 0)
			return 1;
		if (r > FRAME_MAX)
			return FRAME_MAX;
		return int'(r);
	endfunction

	function automatic logic [11:0] clamp12(logic signed [15:0] c);
		if (c < 0)
			return 12'd0;
		if (c > 4095)
			return 12'd4095;
		return c[11:0];
	endfunction

	// clear, put with depth test and get; returns the result the item should produce
	function automatic zbfs_pkg::result_t predict_pixel_op(zbfs_pkg::item_t it);
		zbfs_pkg::result_t r;
		int w;
		int h;
		int x;
		int y;
		int idx;
		longint d;
		r = '0;
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		x = int'(it.pixel_x);
		y = int'(it.pixel_y);
		d = longint'(it.depth_in);
		if (it.operation == zbfs_pkg::OP_CLEAR) begin
			wipe_frame_model();
			return r;
		end
		if (it.operation == zbfs_pkg::OP_NONE)
			return r;
		if (x < 0 || x >= w || y < 0 || y >= h) begin
			r.status = zbfs_pkg::STS_BOUNDS;
			return r;
		end
		idx = y * w + x;
		if (it.operation == zbfs_pkg::OP_PUT) begin
			// bounds first, then sign, then depth; equal depth wins
			if (d < 0)
				r.status = zbfs_pkg::STS_NEGATIVE;
			else if (d > longint'(px_mem[idx].depth))
				r.status = zbfs_pkg::STS_HIDDEN;
			else begin
				px_mem[idx].red = clamp12(it.red_in);
				px_mem[idx].green = clamp12(it.green_in);
				px_mem[idx].blue = clamp12(it.blue_in);
				px_mem[idx].alpha = it.alpha_in;
				px_mem[idx].depth = it.depth_in[30:0];
			end
			return r;
		end
		r.red_out = px_mem[idx].red;
		r.green_out = px_mem[idx].green;
		r.blue_out = px_mem[idx].blue;
		r.alpha_out = px_mem[idx].alpha;
		r.depth_out = px_mem[idx].depth;
		return r;
	endfunction

	function automatic zbfs_pkg::item_t mk_item(zbfs_pkg::op_t op, int x, int y, int rd, int gr,
			int bl, int al, int d);
		zbfs_pkg::item_t it;
		it.operation = op;
		it.pixel_x = 16'(x);
		it.pixel_y = 16'(y);
		it.red_in = 16'(rd);
		it.green_in = 16'(gr);
		it.blue_in = 16'(bl);
		it.alpha_in = 16'(al);
		it.depth_in = 32'(d);
		return it;
	endfunction

	function automatic zbfs_pkg::result_t mk_res(zbfs_pkg::status_t s, int rd, int gr, int bl,
			int al, int d);
		zbfs_pkg::result_t r;
		r.status = s;
		r.red_out = 12'(rd);
		r.green_out = 12'(gr);
		r.blue_out = 12'(bl);
		r.alpha_out = 16'(al);
		r.depth_out = 31'(d);
		return r;
	endfunction

	function automatic int coord_pick(int lim);
		int hot;
		hot = (lim < 8) ? lim : 8;
		return $urandom_range(0, 3) != 0 ? $urandom_range(0, hot - 1) : $urandom_range(0, lim - 1);
	endfunction

	function automatic int colour_pick();
		return $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom;
	endfunction

	// mostly in-frame puts and gets over a small hot window with small depths,
	// so hidden and equal-depth cases come up often; the rest is out-of-frame noise
	function automatic zbfs_pkg::item_t rand_pixel_item();
		zbfs_pkg::item_t it;
		zbfs_pkg::op_t op;
		int w;
		int h;
		int x;
		int y;
		int d;
		int n;
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		n = $urandom_range(0, 99);
		x = coord_pick(w);
		y = coord_pick(h);
		case ($urandom_range(0, 9))
			7: begin
				x = $urandom;
				y = $urandom;
			end
			8: begin
				if ($urandom_range(0, 1))
					x = $urandom_range(0, 1) ? -1 : w;
				else
					y = $urandom_range(0, 1) ? -1 : h;
			end
			9: begin
				x = $urandom_range(0, 1) ? 32767 : -32768;
			end
			default: ;
		endcase
		case ($urandom_range(0, 9))
			7: d = $urandom;
			8: d = $urandom_range(0, 1) ? -int'($urandom_range(1, 1000)) : int'(32'h8000_0000 | $urandom);
			9: d = 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: d = $urandom_range(0, 63);
		endcase
		if (n < 48)
			op = zbfs_pkg::OP_PUT;
		else if (n < 94)
			op = zbfs_pkg::OP_GET;
		else
			op = zbfs_pkg::OP_NONE;
		it = mk_item(op, x, y, colour_pick(), colour_pick(), colour_pick(), $urandom, d);
		return it;
	endfunction

	task automatic send_item(zbfs_pkg::item_t it, bit typed, zbfs_pkg::result_t typed_res);
		zbfs_pkg::result_t r;
		@(negedge clk);
		item = it;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		r = predict_pixel_op(it);
		expected_px.push_back(typed ? typed_res : r);
	endtask

	task automatic pause_sender(int unsigned n);
		@(negedge clk);
		item_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_results_drained();
		pause_sender(1);
		while (expected_px.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(logic [zbfs_pkg::PADDR_W-1:0] addr, logic [8:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = $urandom;
		pwdata[8:0] = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == REG_WIDTH)
			cfg_width = val;
		else
			cfg_height = val;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// receiver: picks a new stall pattern each time its random span runs out
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(20, 120);
		end else
			stall_span <= stall_span - 1;
		case (stall_mode)
			0: result_ready <= 1'b1;
			1: result_ready <= 1'($urandom_range(0, 1));
			2: result_ready <= (rx_tick % 5 == 0);
			default: result_ready <= (rx_tick[3:0] >= 10);
		endcase
		rx_tick <= rx_tick + 1;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_px.size() == 0) begin
				$display("%0t: result with no item outstanding: status %0d", $time, result.status);
				fail_count++;
			end else begin
				want_px = expected_px.pop_front();
				check_field("status", want_px.status, result.status);
				check_field("red_out", want_px.red_out, result.red_out);
				check_field("green_out", want_px.green_out, result.green_out);
				check_field("blue_out", want_px.blue_out, result.blue_out);
				check_field("alpha_out", want_px.alpha_out, result.alpha_out);
				check_field("depth_out", want_px.depth_out, result.depth_out);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("zbuffer_frame_store_unit regression: fail");
			$finish;
		end
	end

	initial begin
		dir_row_t rows[$];
		int phase_w[PHASE_COUNT];
		int phase_h[PHASE_COUNT];
		int burst_left;
		int p;
		int k;
		zbfs_pkg::item_t it;

		arst_n = 1'b0;
		item = '0;
		item_valid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		cfg_width = 9'd256;
		cfg_height = 9'd256;
		wipe_frame_model();

		phase_w = '{256, 1, 0, 511, 8, 256, 1, 13, 257, 0};
		phase_h = '{256, 1, 0, 300, 5, 1, 256, 29, 256, 0};
		phase_w[PHASE_COUNT-1] = $urandom_range(2, 40);
		phase_h[PHASE_COUNT-1] = $urandom_range(2, 40);

		// directed part at the reset resolution of 256 x 256
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 2032, 1776, 1520, 1, 32'h7FFF_FFFF)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 255, 255, 0, 0, 0, 0, 0), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 2032, 1776, 1520, 1, 32'h7FFF_FFFF)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, -1, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(zbfs_pkg::STS_BOUNDS, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 256, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(zbfs_pkg::STS_BOUNDS, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 0, -32768, 0, 0, 0, 0, 0), 1'b1,
			mk_res(zbfs_pkg::STS_BOUNDS, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 32767, 0, 1, 1, 1, 1, 5), 1'b1,
			mk_res(zbfs_pkg::STS_BOUNDS, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 0, 256, 1, 1, 1, 1, 5), 1'b1,
			mk_res(zbfs_pkg::STS_BOUNDS, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 3, 4, 9, 9, 9, 9, -1), 1'b1,
			mk_res(zbfs_pkg::STS_NEGATIVE, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 3, 4, 9, 9, 9, 9, 32'h8000_0000), 1'b1,
			mk_res(zbfs_pkg::STS_NEGATIVE, 0, 0, 0, 0, 0)});
		// out of frame takes precedence over negative depth
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, -1, 4, 9, 9, 9, 9, -1), 1'b1,
			mk_res(zbfs_pkg::STS_BOUNDS, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 3, 4, -32768, 32767, 4096, -32768,
			32'h7FFF_FFFF), 1'b1, mk_res(zbfs_pkg::STS_OK, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 3, 4, 0, 0, 0, 0, 0), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 0, 4095, 4095, -32768, 32'h7FFF_FFFF)});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 3, 4, 4095, 0, -1, 32767, 100), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 3, 4, 5, 5, 5, 5, 101), 1'b1,
			mk_res(zbfs_pkg::STS_HIDDEN, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 3, 4, 1, 2, 3, 0, 100), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 3, 4, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk_item(zbfs_pkg::OP_NONE, -1, -1, -1, -1, -1, -1, -1), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 3, 4, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 255, 255, 4095, 4095, 4095, -1, 0), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 255, 255, 0, 0, 0, 0, 0), 1'b0, '0});
		// put then get of the same pixel back to back
		rows.push_back('{mk_item(zbfs_pkg::OP_PUT, 7, 7, 10, 20, 30, 40, 50), 1'b0, '0});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 7, 7, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{mk_item(zbfs_pkg::OP_CLEAR, 3, 4, 1, 2, 3, 4, 5), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 3, 4, 0, 0, 0, 0, 0), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 2032, 1776, 1520, 1, 32'h7FFF_FFFF)});
		rows.push_back('{mk_item(zbfs_pkg::OP_GET, 255, 255, 0, 0, 0, 0, 0), 1'b1,
			mk_res(zbfs_pkg::STS_OK, 2032, 1776, 1520, 1, 32'h7FFF_FFFF)});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_item(rows[i].it, rows[i].typed, rows[i].res);

		burst_left = 0;
		for (p = 0; p < PHASE_COUNT; p++) begin
			// resolution changes only with the pipeline empty
			wait_results_drained();
			repeat (4) @(posedge clk);
			apb_write(REG_WIDTH, 9'(phase_w[p]));
			apb_write(REG_HEIGHT, 9'(phase_h[p]));
			for (k = 0; k < PHASE_ITEMS; k++) begin
				it = rand_pixel_item();
				if (p % 3 == 2 && k == PHASE_ITEMS / 2)
					it.operation = zbfs_pkg::OP_CLEAR;
				send_item(it, 1'b0, '0);
				if (burst_left > 0)
					burst_left--;
				else begin
					pause_sender($urandom_range(1, 12));
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
						: $urandom_range(0, 15);
				end
			end
		end

		wait_results_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("zbuffer_frame_store_unit regression: pass");
		else
			$display("zbuffer_frame_store_unit regression: fail");
		$finish;
	end

endmodule
